/* sv/address_window_merge_table_core_defines.svh */
// Assertion helpers for the asserting RTL file, the table core.
// Both sample on clk_i; the first also waits out reset on rst_ni.
`ifndef ADDRESS_WINDOW_MERGE_TABLE_CORE_DEFINES_SVH
`define ADDRESS_WINDOW_MERGE_TABLE_CORE_DEFINES_SVH

// Check a property outside of reset.
`define AWMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define AWMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/awmt_pkg.sv */
package awmt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_W            = 64;
  localparam int unsigned FLAGS_W           = 32;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned SLOT_W            = 4;
  localparam int unsigned USED_W            = 5;

  // Address plus a carry bit, for the no-wrap adjacency test.
  typedef logic [ADDR_W:0] addr_x_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MERGED   = 2'd0,
    ST_APPENDED = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  win_start;
    logic [ADDR_W-1:0]  win_end;
    logic [FLAGS_W-1:0] flags;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* sv/awmt_if.sv */
interface awmt_req_if import awmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  window_start;
  logic [ADDR_W-1:0]  window_end;
  logic [FLAGS_W-1:0] window_flags;
  logic               merge_request;

  modport source (output valid, window_start, window_end, window_flags, merge_request,
                  input ready);
  modport sink   (input valid, window_start, window_end, window_flags, merge_request,
                  output ready);
endinterface

interface awmt_rsp_if import awmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W-1:0]   result_start;
  logic [ADDR_W-1:0]   result_end;
  logic [USED_W-1:0]   entries_used;

  modport source (output valid, status, slot, result_start, result_end, entries_used,
                  input ready);
  modport sink   (input valid, status, slot, result_start, result_end, entries_used,
                  output ready);
endinterface

/* sv/awmt_ram.sv */
module awmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/address_window_merge_table_core.sv */
// Path: an ignored request goes from idle straight to the result state, a plain
//   append passes through the append state, a merge scan makes one table read per cycle.
// Throughput: one request at a time; the next request is taken once the result has
//   moved into the output register.
// Reset: clears the entry count, the control state and the output valid; table
//   contents stay undefined and are never read before written, so no clearing pass.
`include "address_window_merge_table_core_defines.svh"

module address_window_merge_table_core import awmt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  awmt_req_if.sink    req_i,
  awmt_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  // FSM and scan control
  state_e          state_q, state_d;
  logic [CW-1:0]   used_q;      // valid entries, slots 0 .. used_q-1
  logic [CW-1:0]   iss_q;       // next slot to read during a scan
  logic            cmp_vld_q;   // RAM read data belongs to a scanned slot
  logic [AW-1:0]   cmp_idx_q;   // slot of that read data

  // Request held for the duration of the item
  logic [ADDR_W-1:0]  ws_q, we_q;
  logic [FLAGS_W-1:0] wf_q;
  logic               mrg_q;

  // Result held until the output register is free
  status_e            res_status_q;
  logic [AW-1:0]      res_slot_q;
  logic [ADDR_W-1:0]  res_start_q, res_end_q;

  // Output register
  logic               out_vld_q;
  status_e            out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [ADDR_W-1:0]  out_start_q, out_end_q;
  logic [USED_W-1:0]  out_used_q;

  // RAM port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  entry_t             rd_entry;

  logic req_acc, ignore_in, out_free, table_full, issue_more;
  logic gap_lo, gap_hi, hit, scan_done;
  logic [ADDR_W-1:0] union_start, union_end;
  logic res_from_accept, res_from_hit, res_from_append, out_load;

  // ---------------------------------------------------------------------------
  // Table storage: one entry per slot, start/end/flags packed side by side.
  // Reads and writes of one item never overlap the next item's reads: the
  // write lands in the scan-hit or append cycle, and at least the result and
  // idle cycles pass before the next scan issues a read.
  // ---------------------------------------------------------------------------
  awmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  assign req_acc    = req_i.valid && req_i.ready;
  // Drop empty windows and windows that start at the all-ones address.
  assign ignore_in  = (req_i.window_start > req_i.window_end) || (&req_i.window_start);
  assign out_free   = !out_vld_q || rsp_o.ready;
  assign table_full = (used_q == CW'(TABLE_ENTRIES));
  assign issue_more = (iss_q != used_q);
  // All issued reads compared and none hit: fall back to append.
  assign scan_done  = !cmp_vld_q && !issue_more;

  // Windows are disjoint with a gap when one starts more than one address past
  // the other's end. The extra carry bit keeps end + 1 from wrapping at the top,
  // so a stored or new end of all-ones never leaves a gap above it.
  assign gap_lo = {1'b0, ws_q} > ({1'b0, rd_entry.win_end} + addr_x_t'(1));
  assign gap_hi = {1'b0, rd_entry.win_start} > ({1'b0, we_q} + addr_x_t'(1));
  assign hit    = cmp_vld_q && (rd_entry.flags == wf_q) && !gap_lo && !gap_hi;

  assign union_start = (ws_q < rd_entry.win_start) ? ws_q : rd_entry.win_start;
  assign union_end   = (we_q > rd_entry.win_end)   ? we_q : rd_entry.win_end;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          priority if (ignore_in)           state_d = S_RESP;
          else if (req_i.merge_request)     state_d = S_SCAN;
          else                              state_d = S_APPEND;
        end
      end
      S_SCAN: begin
        priority if (hit)    state_d = S_RESP;
        else if (scan_done)  state_d = S_APPEND;
      end
      S_APPEND: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    req_i.ready     = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cmp_idx_q;
    ram_wdata       = '{win_start: union_start, win_end: union_end, flags: wf_q};
    res_from_accept = 1'b0;
    res_from_hit    = 1'b0;
    res_from_append = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready     = 1'b1;
        res_from_accept = req_acc && ignore_in;
      end
      S_SCAN: begin
        // Grow the first matching entry in place.
        ram_we       = hit;
        res_from_hit = hit;
      end
      S_APPEND: begin
        ram_we          = !table_full;
        ram_waddr       = used_q[AW-1:0];
        ram_wdata       = '{win_start: ws_q, win_end: we_q, flags: wf_q};
        res_from_append = 1'b1;
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_acc) begin
        // Restart the scan for the new request.
        iss_q     <= '0;
        cmp_vld_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        // Issue one read a cycle; cmp_vld_q and cmp_idx_q tag the registered RAM data for the compare.
        cmp_vld_q <= issue_more;
        cmp_idx_q <= iss_q[AW-1:0];
        if (issue_more) iss_q <= iss_q + CW'(1);
      end
      if (state_q == S_APPEND && !table_full) begin
        used_q <= used_q + CW'(1);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      ws_q  <= req_i.window_start;
      we_q  <= req_i.window_end;
      wf_q  <= req_i.window_flags;
      mrg_q <= req_i.merge_request;
    end
    priority if (res_from_accept) begin
      res_status_q <= ST_IGNORED;
      res_slot_q   <= '0;
      res_start_q  <= '0;
      res_end_q    <= '0;
    end else if (res_from_hit) begin
      res_status_q <= ST_MERGED;
      res_slot_q   <= cmp_idx_q;
      res_start_q  <= union_start;
      res_end_q    <= union_end;
    end else if (res_from_append) begin
      if (table_full) begin
        res_status_q <= ST_FULL;
        res_slot_q   <= '0;
        res_start_q  <= '0;
        res_end_q    <= '0;
      end else begin
        res_status_q <= ST_APPENDED;
        res_slot_q   <= used_q[AW-1:0];
        res_start_q  <= ws_q;
        res_end_q    <= we_q;
      end
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= SLOT_W'(res_slot_q);
      out_start_q  <= res_start_q;
      out_end_q    <= res_end_q;
      out_used_q   <= USED_W'(used_q);
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot         = out_slot_q;
  assign rsp_o.result_start = out_start_q;
  assign rsp_o.result_end   = out_end_q;
  assign rsp_o.entries_used = out_used_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `AWMT_ASSERT_ALWAYS(a_used_bound, used_q <= CW'(TABLE_ENTRIES), "entry count beyond table size")
  `AWMT_ASSERT(a_cmp_in_range, cmp_vld_q |-> (CW'(cmp_idx_q) < used_q), "scan compared an unused slot")
  `AWMT_ASSERT(a_append_grows, (state_q == S_APPEND && !table_full) |=> used_q == $past(used_q) + CW'(1), "append did not grow the table")
  `AWMT_ASSERT(a_merge_keeps, (state_q == S_SCAN) |=> used_q == $past(used_q), "scan changed the entry count")
  `AWMT_ASSERT(a_merge_only_req, (state_q == S_SCAN) |-> mrg_q, "scan without a merge request")

endmodule

/* test/tb_address_window_merge_table_core.sv */
module tb_address_window_merge_table_core;
  import awmt_pkg::*;

  localparam int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int unsigned TOTAL_WINDOWS = 1100;
  localparam int unsigned PHASE_LEN     = 367;
  localparam int unsigned DRAIN_CYCLES  = 30;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned REPORT_MAX    = 10;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  // One offered window and the table's answer to it.
  typedef struct packed {
    logic [ADDR_W-1:0]  window_start;
    logic [ADDR_W-1:0]  window_end;
    logic [FLAGS_W-1:0] window_flags;
    logic               merge_request;
  } window_req_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   result_start;
    logic [ADDR_W-1:0]   result_end;
    logic [USED_W-1:0]   entries_used;
  } window_result_t;

  // Shapes of a random window placed relative to a stored entry.
  typedef enum int unsigned {
    NEAR_BELOW,
    NEAR_ABOVE,
    GAP_BELOW,
    GAP_ABOVE,
    NEAR_OVERLAP,
    NEAR_COVER
  } near_kind_e;

  logic clk_i;
  logic rst_ni;

  awmt_req_if req_if ();
  awmt_rsp_if rsp_if ();

  address_window_merge_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the window table, updated at each accepted request.
  logic [ADDR_W-1:0]  win_start_tbl [TABLE_ENTRIES];
  logic [ADDR_W-1:0]  win_end_tbl   [TABLE_ENTRIES];
  logic [FLAGS_W-1:0] win_flags_tbl [TABLE_ENTRIES];
  int unsigned        win_count;

  window_req_t    pending_windows [$];
  window_result_t expected_results [$];
  logic [FLAGS_W-1:0] flag_pool [4];

  window_req_t    next_window;
  window_result_t oldest_result;
  int unsigned    windows_queued;
  int unsigned    req_issued;
  int unsigned    req_accepted;
  int unsigned    rsp_checked;
  int unsigned    mismatch_count;
  int unsigned    cycle_count;
  int unsigned    status_tally [4];
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] sub_sat(logic [ADDR_W-1:0] a, int unsigned b);
    return (a > ADDR_W'(b)) ? a - ADDR_W'(b) : '0;
  endfunction

  function automatic logic [ADDR_W-1:0] add_sat(logic [ADDR_W-1:0] a, int unsigned b);
    return (a > ADDR_MAX - ADDR_W'(b)) ? ADDR_MAX : a + ADDR_W'(b);
  endfunction

  // Apply one window to the shadow table and return what the block should report.
  function automatic window_result_t apply_window(window_req_t w);
    window_result_t    r;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    bit                done;
    r.status       = ST_IGNORED;
    r.slot         = '0;
    r.result_start = '0;
    r.result_end   = '0;
    // Empty windows and windows starting at the all-ones address are dropped.
    done = (w.window_start > w.window_end) || (w.window_start == ADDR_MAX);
    if (!done && w.merge_request) begin
      for (int i = 0; i < int'(win_count) && !done; i++) begin
        if (win_flags_tbl[i] == w.window_flags) begin
          lo = (win_start_tbl[i] > w.window_start) ? win_start_tbl[i] : w.window_start;
          hi = (win_end_tbl[i] < w.window_end) ? win_end_tbl[i] : w.window_end;
          // Merge on overlap or direct touch; a gap of one address or more blocks it.
          // lo > hi here, so the difference cannot wrap at the top address.
          if (!(lo > hi && (lo - hi) > 1)) begin
            if (w.window_start < win_start_tbl[i]) win_start_tbl[i] = w.window_start;
            if (w.window_end > win_end_tbl[i]) win_end_tbl[i] = w.window_end;
            r.status       = ST_MERGED;
            r.slot         = SLOT_W'(i);
            r.result_start = win_start_tbl[i];
            r.result_end   = win_end_tbl[i];
            done           = 1'b1;
          end
        end
      end
    end
    if (!done) begin
      if (win_count >= TABLE_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        win_start_tbl[win_count] = w.window_start;
        win_end_tbl[win_count]   = w.window_end;
        win_flags_tbl[win_count] = w.window_flags;
        r.status       = ST_APPENDED;
        r.slot         = SLOT_W'(win_count);
        r.result_start = w.window_start;
        r.result_end   = w.window_end;
        win_count++;
      end
    end
    r.entries_used = USED_W'(win_count);
    return r;
  endfunction

  // Build a random window. Most land next to, inside or around a stored entry
  // so the merge scan gets exercised; the rest are noise, empty windows and windows at the all-ones start.
  function automatic window_req_t random_window();
    window_req_t       w;
    int unsigned       pick;
    int unsigned       len;
    int unsigned       slot;
    near_kind_e        kind;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    pick            = $urandom_range(0, 99);
    len             = $urandom_range(0, 255);
    w.window_flags  = flag_pool[$urandom_range(0, 3)];
    w.merge_request = ($urandom_range(0, 9) != 0);
    if (pick < 10) begin
      w.window_start  = rand_addr();
      w.window_end    = rand_addr();
      w.window_flags  = $urandom;
      w.merge_request = 1'($urandom_range(0, 1));
    end else if (pick < 15) begin
      if ($urandom_range(0, 1) != 0) begin
        w.window_start = ADDR_MAX;
        w.window_end   = ($urandom_range(0, 1) != 0) ? ADDR_MAX : rand_addr();
      end else begin
        s              = rand_addr();
        w.window_start = (s == '0) ? ADDR_W'(1) : s;
        w.window_end   = sub_sat(w.window_start - 1, len);
      end
    end else if (pick < 80 && win_count != 0) begin
      slot = $urandom_range(0, win_count - 1);
      s    = win_start_tbl[slot];
      e    = win_end_tbl[slot];
      w.window_flags = win_flags_tbl[slot];
      if ($urandom_range(0, 6) == 0) w.window_flags ^= FLAGS_W'(1) << $urandom_range(0, 31);
      kind = near_kind_e'($urandom_range(0, 5));
      if ((kind == NEAR_BELOW && s < 1) || (kind == GAP_BELOW && s < 2)) kind = NEAR_OVERLAP;
      if ((kind == NEAR_ABOVE && e == ADDR_MAX) || (kind == GAP_ABOVE && e > ADDR_MAX - 2))
        kind = NEAR_OVERLAP;
      case (kind)
        NEAR_BELOW: begin
          w.window_end   = s - 1;
          w.window_start = sub_sat(s - 1, len);
        end
        NEAR_ABOVE: begin
          w.window_start = e + 1;
          w.window_end   = add_sat(e + 1, len);
        end
        GAP_BELOW: begin
          w.window_end   = s - 2;
          w.window_start = sub_sat(s - 2, len);
        end
        GAP_ABOVE: begin
          w.window_start = e + 2;
          w.window_end   = add_sat(e + 2, len);
        end
        NEAR_OVERLAP: begin
          w.window_start = add_sat(s, len);
          if (w.window_start > e) w.window_start = e;
          w.window_end = add_sat(w.window_start, $urandom_range(0, 255));
        end
        default: begin
          w.window_start = sub_sat(s, len);
          w.window_end   = add_sat(e, $urandom_range(0, 255));
        end
      endcase
    end else begin
      s = rand_addr();
      if ($urandom_range(0, 1) != 0) s &= ADDR_W'(64'hFFF);
      w.window_start = s;
      w.window_end   = add_sat(s, len);
    end
    return w;
  endfunction

  task automatic queue_window(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e,
                              logic [FLAGS_W-1:0] f, logic m);
    window_req_t w;
    w.window_start  = s;
    w.window_end    = e;
    w.window_flags  = f;
    w.merge_request = m;
    pending_windows.push_back(w);
    windows_queued++;
  endtask

  // Idle rates by phase: sender light / receiver heavy, then swapped, then none.
  always_comb begin
    if (req_accepted < PHASE_LEN) begin
      send_idle_pct = 15;
      recv_idle_pct = 45;
    end else if (req_accepted < 2 * PHASE_LEN) begin
      send_idle_pct = 45;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Request driver: present a new window once the previous one is taken,
  // hold it otherwise. Valid gets at most one assignment per falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_accepted == req_issued)) begin
      if (pending_windows.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_window = pending_windows.pop_front();
        req_if.valid         <= 1'b1;
        req_if.window_start  <= next_window.window_start;
        req_if.window_end    <= next_window.window_end;
        req_if.window_flags  <= next_window.window_flags;
        req_if.merge_request <= next_window.merge_request;
        req_issued           <= req_issued + 1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response backpressure: stall at random by phase.
  always @(negedge clk_i) begin
    if (rst_ni) rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted response
  // against the oldest prediction.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        next_window.window_start  = req_if.window_start;
        next_window.window_end    = req_if.window_end;
        next_window.window_flags  = req_if.window_flags;
        next_window.merge_request = req_if.merge_request;
        expected_results.push_back(apply_window(next_window));
        req_accepted <= req_accepted + 1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_MAX)
            $display("ERROR: response with nothing pending: status %0d slot %0d start %h end %h used %0d",
                     rsp_if.status, rsp_if.slot, rsp_if.result_start, rsp_if.result_end,
                     rsp_if.entries_used);
        end else begin
          oldest_result = expected_results.pop_front();
          status_tally[oldest_result.status] <= status_tally[oldest_result.status] + 1;
          rsp_checked <= rsp_checked + 1;
          if (rsp_if.status !== oldest_result.status || rsp_if.slot !== oldest_result.slot ||
              rsp_if.result_start !== oldest_result.result_start ||
              rsp_if.result_end !== oldest_result.result_end ||
              rsp_if.entries_used !== oldest_result.entries_used) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < REPORT_MAX) begin
              $display("ERROR: response %0d expected status %0d slot %0d start %h end %h used %0d",
                       rsp_checked, oldest_result.status, oldest_result.slot,
                       oldest_result.result_start, oldest_result.result_end,
                       oldest_result.entries_used);
              $display("       got      status %0d slot %0d start %h end %h used %0d",
                       rsp_if.status, rsp_if.slot, rsp_if.result_start, rsp_if.result_end,
                       rsp_if.entries_used);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run if the traffic stops making progress.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: timeout after %0d cycles, %0d of %0d requests accepted",
             cycle_count, req_accepted, windows_queued);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.window_start  = '0;
    req_if.window_end    = '0;
    req_if.window_flags  = '0;
    req_if.merge_request = 1'b0;
    rsp_if.ready         = 1'b0;
    win_count            = 0;
    windows_queued       = 0;
    req_issued           = 0;
    req_accepted         = 0;
    rsp_checked          = 0;
    mismatch_count       = 0;
    cycle_count          = 0;
    for (int i = 0; i < 4; i++) status_tally[i] = 0;
    flag_pool[0] = '0;
    flag_pool[1] = '1;
    flag_pool[2] = 32'h0000_00A5;
    flag_pool[3] = $urandom;

    // Directed windows: drop cases, touch on both sides, a gap above, the top
    // address, flag mismatch, forced append, then fill the table past full.
    queue_window(64'h100, 64'hFF, '0, 1'b0);                 // empty window
    queue_window(ADDR_MAX, ADDR_MAX, '1, 1'b1);              // reserved start
    queue_window(64'h0, 64'h0, '0, 1'b0);                    // slot 0
    queue_window(64'h10, 64'h1F, 32'h0000_00A5, 1'b0);       // slot 1
    queue_window(64'h20, 64'h2F, 32'h0000_00A5, 1'b1);       // touches slot 1 above
    queue_window(64'h31, 64'h40, 32'h0000_00A5, 1'b1);       // one-address gap, append
    queue_window(64'h05, 64'h30, 32'h5A00_0000, 1'b1);       // no flag match, append
    queue_window(64'h30, 64'h30, 32'h0000_00A5, 1'b1);       // touches two, first wins
    queue_window(ADDR_MAX - 15, ADDR_MAX - 1, '1, 1'b0);     // near the top
    queue_window(ADDR_MAX - 1, ADDR_MAX, '1, 1'b1);          // grow to all-ones end
    queue_window(ADDR_MAX - 47, ADDR_MAX - 16, '1, 1'b1);    // touches from below
    queue_window(ADDR_MAX, ADDR_MAX, '1, 1'b1);              // reserved, would merge
    queue_window(64'h0, ADDR_MAX, '0, 1'b1);                 // grow slot 0 to everything
    queue_window(64'h0, ADDR_MAX, '0, 1'b0);                 // forced duplicate append
    for (int i = 0; i < 10; i++) begin
      next_window.window_start = rand_addr() & ADDR_W'(64'h0FFF_FFFF_FFFF_FF00);
      queue_window(next_window.window_start, next_window.window_start + 64'h3F,
                   $urandom, 1'b0);
    end
    queue_window(64'h1000, 64'h1FFF, 32'h1234_5678, 1'b0);   // append into a full table
    queue_window(64'h1000, 64'h1FFF, 32'h8765_4321, 1'b1);   // merge miss, full
    queue_window(64'h41, 64'h41, 32'h0000_00A5, 1'b1);       // merge hit while full

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Random windows, generated just ahead of the driver so they can aim at
    // whatever the table holds at that point.
    while (windows_queued < TOTAL_WINDOWS) begin
      @(negedge clk_i);
      if (pending_windows.size() < 4) begin
        pending_windows.push_back(random_window());
        windows_queued++;
      end
    end

    while (req_accepted != windows_queued || pending_windows.size() != 0) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d responses: %0d merged, %0d appended, %0d ignored, %0d table full",
             rsp_checked, status_tally[ST_MERGED], status_tally[ST_APPENDED],
             status_tally[ST_IGNORED], status_tally[ST_FULL]);
    $display("%0d mismatches, %0d responses still pending, %0d cycles",
             mismatch_count, expected_results.size(), cycle_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
